// File: rtl/tsrr_pkg.sv
// ----------------------------------------------------------------------------
// tsrr_pkg
// Shared constants and types for the task slot round-robin scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tsrr_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int ADDR_W_MAX     = 6;

    localparam logic [31:0] IDLE_ENTRY = 32'h0000_0001;

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_KILL = 2'd1;
    localparam logic [1:0] REQ_NEXT = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_RANGE = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_IDLE  = 3'd4;

    typedef struct packed {
        logic                  en;
        logic                  busy;
        logic [ADDR_W_MAX-1:0] addr;
        logic [31:0]           entry;
        logic [31:0]           data;
    } store_wr_t;

endpackage

`default_nettype wire

// File: rtl/tsrr_slot_store.sv
// ----------------------------------------------------------------------------
// tsrr_slot_store
// Slot table: occupied flags in flip-flops, entry and data handles in
// memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrr_slot_store #(
    parameter int SLOT_COUNT = tsrr_pkg::SLOT_COUNT_DEF,
    parameter int AW         = $clog2(SLOT_COUNT)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tsrr_pkg::store_wr_t   wr,
    input  wire logic                  rd_en,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [SLOT_COUNT-1:0] busy,
    output logic      [31:0]           rd_entry,
    output logic      [31:0]           rd_data
);
    import tsrr_pkg::*;

    logic [31:0]           entry_mem [SLOT_COUNT];
    logic [31:0]           data_mem  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] busy_reg;
    logic                  slot0_wr_reg;
    logic                  rd_zero_reg;
    logic [31:0]           rd_entry_reg;
    logic [31:0]           rd_data_reg;
    logic [AW-1:0]         wr_addr;

    assign wr_addr = wr.addr[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= {{(SLOT_COUNT-1){1'b0}}, 1'b1};
            slot0_wr_reg <= 1'b0;
            rd_zero_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                busy_reg[wr_addr] <= wr.busy;
                if (wr_addr == '0)
                begin
                    slot0_wr_reg <= 1'b1;
                end
            end
            if (rd_en)
            begin
                rd_zero_reg <= (rd_addr == '0) && !slot0_wr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            entry_mem[wr_addr] <= wr.entry;
            data_mem[wr_addr]  <= wr.data;
        end
        if (rd_en)
        begin
            rd_entry_reg <= entry_mem[rd_addr];
            rd_data_reg  <= data_mem[rd_addr];
        end
    end

    assign busy     = busy_reg;
    assign rd_entry = rd_zero_reg ? IDLE_ENTRY : rd_entry_reg;
    assign rd_data  = rd_zero_reg ? 32'd0 : rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/task_slot_round_robin_scheduler_core.sv
// ----------------------------------------------------------------------------
// task_slot_round_robin_scheduler_core
// Round-robin task scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// One request beat in, one result beat out. The slot table is searched by a
// single stepper that tests one slot per cycle; an add tests 1 to SLOT_COUNT
// slots, a next 1 to SLOT_COUNT-1 slots, and a kill or unknown request none.
// The handles sit in a memory with a registered read, which adds a read
// state for next.
// The input is taken again as soon as the result is in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module task_slot_round_robin_scheduler_core #(
    parameter int SLOT_COUNT = tsrr_pkg::SLOT_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // req_type[1:0], slot_id[9:2], entry_handle[41:10], data_handle[73:42]
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], slot_index[6:3], switched[7], run_entry[39:8], run_data[71:40]
    output logic      [71:0] m_tdata
);
    import tsrr_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);
    localparam logic [AW-1:0] ONE  = AW'(1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  state_reg,  state_next;
    logic [AW-1:0] idx_reg,  idx_next;
    logic [AW-1:0] rem_reg,  rem_next;
    logic [AW-1:0] cur_reg,  cur_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [71:0] m_tdata_reg,  m_tdata_next;

    logic [1:0]  req_reg,    req_next;
    logic [7:0]  id_reg,     id_next;
    logic [31:0] entry_reg,  entry_next;
    logic [31:0] data_reg,   data_next;
    logic [2:0]  status_reg, status_next;
    logic [3:0]  sidx_reg,   sidx_next;
    logic        sw_reg,     sw_next;
    logic        run_reg,    run_next;

    store_wr_t             wr;
    logic                  rd_en;
    logic [SLOT_COUNT-1:0] busy;
    logic [31:0]           rd_entry;
    logic [31:0]           rd_data;

    logic          accept;
    logic          is_add;
    logic          hit;
    logic [AW-1:0] idx_step;
    logic [AW-1:0] cand0;
    logic [AW-1:0] kill_addr;
    logic [7:0]    idx_wide;
    logic [7:0]    cur_wide;
    logic          can_load;

    tsrr_slot_store #(
        .SLOT_COUNT(SLOT_COUNT),
        .AW        (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (cur_reg),
        .busy    (busy),
        .rd_entry(rd_entry),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign is_add    = (req_reg == REQ_ADD);
    assign hit       = is_add ? !busy[idx_reg] : busy[idx_reg];
    assign idx_step  = (!is_add && idx_reg == LAST) ? ONE : idx_reg + ONE;
    assign cand0     = (cur_reg == LAST) ? ONE : cur_reg + ONE;
    assign kill_addr = id_reg[AW-1:0];
    assign idx_wide  = 8'(idx_reg);
    assign cur_wide  = 8'(cur_reg);
    assign can_load  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        rem_next      = rem_reg;
        cur_next      = cur_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        req_next      = req_reg;
        id_next       = id_reg;
        entry_next    = entry_reg;
        data_next     = data_reg;
        status_next   = status_reg;
        sidx_next     = sidx_reg;
        sw_next       = sw_reg;
        run_next      = run_reg;
        rd_en         = 1'b0;
        wr            = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = s_tdata[1:0];
                    id_next    = s_tdata[9:2];
                    entry_next = s_tdata[41:10];
                    data_next  = s_tdata[73:42];
                    sw_next    = 1'b0;
                    run_next   = 1'b0;
                    if (s_tdata[1:0] == REQ_ADD)
                    begin
                        idx_next   = '0;
                        rem_next   = LAST;
                        state_next = S_SCAN;
                    end
                    else if (s_tdata[1:0] == REQ_NEXT)
                    begin
                        idx_next   = cand0;
                        rem_next   = AW'(SLOT_COUNT - 2);
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    status_next = ST_OK;
                    sidx_next   = idx_wide[3:0];
                    if (is_add)
                    begin
                        wr.en      = (entry_reg != 32'd0);
                        wr.busy    = 1'b1;
                        wr.addr    = ADDR_W_MAX'(idx_reg);
                        wr.entry   = entry_reg;
                        wr.data    = data_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cur_next   = idx_reg;
                        sw_next    = (idx_reg != cur_reg);
                        run_next   = 1'b1;
                        state_next = S_READ;
                    end
                end
                else if (rem_reg == '0)
                begin
                    sidx_next = 4'd0;
                    if (is_add)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        status_next = ST_IDLE;
                        cur_next    = '0;
                        sw_next     = (cur_reg != '0);
                        run_next    = 1'b1;
                        state_next  = S_READ;
                    end
                end
                else
                begin
                    idx_next = idx_step;
                    rem_next = rem_reg - ONE;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                if (req_reg == REQ_KILL)
                begin
                    if (id_reg >= 8'(SLOT_COUNT))
                    begin
                        status_next = ST_RANGE;
                        sidx_next   = 4'd0;
                    end
                    else
                    begin
                        sidx_next = id_reg[3:0];
                        if (!busy[kill_addr])
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            wr.en       = 1'b1;
                            wr.busy     = 1'b0;
                            wr.addr     = ADDR_W_MAX'(kill_addr);
                        end
                    end
                end
                else
                begin
                    status_next = ST_RANGE;
                    sidx_next   = cur_wide[3:0];
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (can_load)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {run_reg ? rd_data : 32'd0,
                                     run_reg ? rd_entry : 32'd0,
                                     sw_reg, sidx_reg, status_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        rem_reg     <= rem_next;
        m_tdata_reg <= m_tdata_next;
        req_reg     <= req_next;
        id_reg      <= id_next;
        entry_reg   <= entry_next;
        data_reg    <= data_next;
        status_reg  <= status_next;
        sidx_reg    <= sidx_next;
        sw_reg      <= sw_next;
        run_reg     <= run_next;
    end

    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_reg) < SLOT_COUNT)
        else $error("current slot out of range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input taken again during a request");

    a_read_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_OUT))
        else $error("handle read not followed by result load");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result beat raised outside result load");

endmodule

`default_nettype wire
